FILE: rtl/core/ssp_pkg.sv
package ssp_pkg;

  // register indexes of the configuration port
  localparam logic CFG_STRIP_WIDTH = 1'b0;
  localparam logic CFG_FIT_MODE    = 1'b1;

  localparam logic [15:0] STRIP_WIDTH_RST = 16'd100;
  localparam logic        FIT_MODE_RST    = 1'b1;

  localparam logic FIT_NEXT  = 1'b0;
  localparam logic FIT_FIRST = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_RDI,
    ST_RK_CAPI,
    ST_RK_RDJ,
    ST_RK_CMP,
    ST_RK_WR,
    ST_PK_RDO,
    ST_PK_RDR,
    ST_PK_CAP,
    ST_PK_RDS,
    ST_PK_CHK,
    ST_PK_ADD,
    ST_PK_OPEN,
    ST_OT_RDP,
    ST_OT_RDH,
    ST_OT_EMIT
  } ssp_state_t;

  typedef struct packed {
    logic load;
    logic rk_rdi;
    logic rk_capi;
    logic rk_rdj;
    logic rk_cmp;
    logic rk_wr;
    logic pk_rdo;
    logic pk_rdr;
    logic pk_cap;
    logic pk_rds;
    logic pk_chk;
    logic pk_add;
    logic pk_open;
    logic ot_rdp;
    logic ot_rdh;
    logic ot_emit;
  } ssp_cmd_t;

  typedef struct packed {
    logic last_beat;
    logic j_last;
    logic i_last;
    logic no_shelf;
    logic fits;
    logic s_last;
    logic k_last;
    logic out_free;
  } ssp_stat_t;

endpackage

FILE: rtl/core/ssp_in_if.sv
interface ssp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic        last_rect;

  modport source (output valid, output rect_width, output rect_height, output last_rect,
                  input ready);
  modport sink (input valid, input rect_width, input rect_height, input last_rect,
                output ready);
endinterface

FILE: rtl/core/ssp_out_if.sv
interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  shelf_index;
  logic [4:0]  slot_index;
  logic [15:0] shelf_height;
  logic [5:0]  shelf_count;
  logic        overflow;
  logic        last_result;

  modport source (output valid, output shelf_index, output slot_index, output shelf_height,
                  output shelf_count, output overflow, output last_result, input ready);
  modport sink (input valid, input shelf_index, input slot_index, input shelf_height,
                input shelf_count, input overflow, input last_result, output ready);
endinterface

FILE: rtl/core/ssp_ram.sv
module ssp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/ssp_ctrl.sv
module ssp_ctrl import ssp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ssp_stat_t stat,
  output ssp_cmd_t  cmd
);
  ssp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:    if (stat.last_beat) state_nxt = ST_RK_RDI;
      ST_RK_RDI:  state_nxt = ST_RK_CAPI;
      ST_RK_CAPI: state_nxt = ST_RK_RDJ;
      ST_RK_RDJ:  state_nxt = ST_RK_CMP;
      ST_RK_CMP:  state_nxt = stat.j_last ? ST_RK_WR : ST_RK_RDJ;
      ST_RK_WR:   state_nxt = stat.i_last ? ST_PK_RDO : ST_RK_RDI;
      ST_PK_RDO:  state_nxt = ST_PK_RDR;
      ST_PK_RDR:  state_nxt = ST_PK_CAP;
      ST_PK_CAP:  state_nxt = stat.no_shelf ? ST_PK_OPEN : ST_PK_RDS;
      ST_PK_RDS:  state_nxt = ST_PK_CHK;
      ST_PK_CHK: begin
        if (stat.fits) begin
          state_nxt = ST_PK_ADD;
        end else if (stat.s_last) begin
          state_nxt = ST_PK_OPEN;
        end else begin
          state_nxt = ST_PK_RDS;
        end
      end
      ST_PK_ADD,
      ST_PK_OPEN: state_nxt = stat.k_last ? ST_OT_RDP : ST_PK_RDO;
      ST_OT_RDP:  state_nxt = ST_OT_RDH;
      ST_OT_RDH:  state_nxt = ST_OT_EMIT;
      ST_OT_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.k_last ? ST_LOAD : ST_OT_RDP;
        end
      end
      default:    state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_LOAD:    cmd.load    = 1'b1;
      ST_RK_RDI:  cmd.rk_rdi  = 1'b1;
      ST_RK_CAPI: cmd.rk_capi = 1'b1;
      ST_RK_RDJ:  cmd.rk_rdj  = 1'b1;
      ST_RK_CMP:  cmd.rk_cmp  = 1'b1;
      ST_RK_WR:   cmd.rk_wr   = 1'b1;
      ST_PK_RDO:  cmd.pk_rdo  = 1'b1;
      ST_PK_RDR:  cmd.pk_rdr  = 1'b1;
      ST_PK_CAP:  cmd.pk_cap  = 1'b1;
      ST_PK_RDS:  cmd.pk_rds  = 1'b1;
      ST_PK_CHK:  cmd.pk_chk  = 1'b1;
      ST_PK_ADD:  cmd.pk_add  = 1'b1;
      ST_PK_OPEN: cmd.pk_open = 1'b1;
      ST_OT_RDP:  cmd.ot_rdp  = 1'b1;
      ST_OT_RDH:  cmd.ot_rdh  = 1'b1;
      ST_OT_EMIT: cmd.ot_emit = 1'b1;
      default:    cmd = '0;
    endcase
  end
endmodule

FILE: rtl/core/ssp_dp.sv
module ssp_dp import ssp_pkg::*; #(
  parameter int MAX_RECTS = 32,
  parameter int DIM_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ssp_in_if.sink       in_ch,
  ssp_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  ssp_cmd_t     cmd,
  output ssp_stat_t    stat
);
  localparam int IDX_W = $clog2(MAX_RECTS);
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int UW    = (DIM_BITS > 16) ? DIM_BITS : 16;
  localparam int SUM_W = UW + 1;
  localparam int SHF_W = UW + CNT_W;
  localparam int PLC_W = 2 * IDX_W;

  logic [15:0]         strip_r;
  logic                fit_r;
  logic [CNT_W-1:0]    cnt_r, shelves_r;
  logic                drop_r;
  logic [IDX_W-1:0]    i_r, j_r, rank_r, k_r, s_r, r_r, pshelf_r, pslot_r;
  logic [DIM_BITS-1:0] hi_r, w_r, h_r;
  logic [UW-1:0]       used_r;
  logic [CNT_W-1:0]    fill_r;

  logic                out_valid_r;
  logic [4:0]          o_shelf_r, o_slot_r;
  logic [15:0]         o_height_r;
  logic [5:0]          o_count_r;
  logic                o_ovf_r, o_last_r;

  // ram ports
  logic                accept, store;
  logic [IDX_W-1:0]    hgt_raddr, sh_raddr;
  logic [DIM_BITS-1:0] wid_rdata, hgt_rdata, sh_rdata;
  logic [IDX_W-1:0]    ord_rdata;
  logic [SHF_W-1:0]    shf_rdata, shf_wdata;
  logic                shf_we;
  logic [IDX_W-1:0]    shf_waddr;
  logic [PLC_W-1:0]    plc_rdata, plc_wdata;
  logic                plc_we;
  logic [UW-1:0]       rd_used;
  logic [CNT_W-1:0]    rd_fill;
  logic [SUM_W-1:0]    sum;
  logic                out_free;
  logic                rank_up;

  assign accept = cmd.load && in_ch.valid;
  assign store  = accept && (cnt_r < CNT_W'(MAX_RECTS));
  assign in_ch.ready = cmd.load;

  assign rd_used = shf_rdata[UW-1:0];
  assign rd_fill = shf_rdata[SHF_W-1:UW];
  assign sum     = SUM_W'(rd_used) + SUM_W'(w_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign rank_up = (hgt_rdata > hi_r) || ((hgt_rdata == hi_r) && (j_r < i_r));

  always_comb begin
    if (cmd.rk_rdi) begin
      hgt_raddr = i_r;
    end else if (cmd.pk_rdr) begin
      hgt_raddr = ord_rdata;
    end else begin
      hgt_raddr = j_r;
    end
  end

  assign sh_raddr = cmd.ot_rdh ? plc_rdata[PLC_W-1:IDX_W] : pshelf_r;

  always_comb begin
    shf_we    = 1'b0;
    shf_waddr = s_r;
    shf_wdata = {fill_r + CNT_W'(1), used_r + UW'(w_r)};
    plc_we    = 1'b0;
    plc_wdata = {s_r, fill_r[IDX_W-1:0]};
    if (cmd.pk_add) begin
      shf_we = 1'b1;
      plc_we = 1'b1;
    end else if (cmd.pk_open) begin
      shf_we    = 1'b1;
      shf_waddr = shelves_r[IDX_W-1:0];
      shf_wdata = {CNT_W'(1), UW'(w_r)};
      plc_we    = 1'b1;
      plc_wdata = {shelves_r[IDX_W-1:0], IDX_W'(0)};
    end
  end

  ssp_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_RECTS)) u_wid (
    .clk, .we(store), .waddr(cnt_r[IDX_W-1:0]), .wdata(DIM_BITS'(in_ch.rect_width)),
    .raddr(ord_rdata), .rdata(wid_rdata)
  );

  ssp_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_RECTS)) u_hgt (
    .clk, .we(store), .waddr(cnt_r[IDX_W-1:0]), .wdata(DIM_BITS'(in_ch.rect_height)),
    .raddr(hgt_raddr), .rdata(hgt_rdata)
  );

  ssp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECTS)) u_ord (
    .clk, .we(cmd.rk_wr), .waddr(rank_r), .wdata(i_r),
    .raddr(k_r), .rdata(ord_rdata)
  );

  ssp_ram #(.WIDTH(SHF_W), .DEPTH(MAX_RECTS)) u_shf (
    .clk, .we(shf_we), .waddr(shf_waddr), .wdata(shf_wdata),
    .raddr(s_r), .rdata(shf_rdata)
  );

  ssp_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_RECTS)) u_sh (
    .clk, .we(cmd.pk_open), .waddr(shelves_r[IDX_W-1:0]), .wdata(h_r),
    .raddr(sh_raddr), .rdata(sh_rdata)
  );

  ssp_ram #(.WIDTH(PLC_W), .DEPTH(MAX_RECTS)) u_plc (
    .clk, .we(plc_we), .waddr(r_r), .wdata(plc_wdata),
    .raddr(k_r), .rdata(plc_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= STRIP_WIDTH_RST;
      fit_r   <= FIT_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIP_WIDTH: strip_r <= cfg_wdata;
        CFG_FIT_MODE:    fit_r   <= cfg_wdata[0];
        default:         strip_r <= strip_r;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      shelves_r <= '0;
      i_r       <= '0;
      k_r       <= '0;
    end else begin
      if (store) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (accept) begin
        drop_r <= 1'b1;
      end
      if (cmd.load) begin
        i_r       <= '0;
        k_r       <= '0;
        shelves_r <= '0;
      end
      if (cmd.rk_wr) begin
        i_r <= i_r + IDX_W'(1);
      end
      if (cmd.pk_open) begin
        shelves_r <= shelves_r + CNT_W'(1);
      end
      if (cmd.pk_add || cmd.pk_open) begin
        k_r <= stat.k_last ? '0 : k_r + IDX_W'(1);
      end
      if (cmd.ot_emit && out_free) begin
        k_r <= k_r + IDX_W'(1);
        if (stat.k_last) begin
          cnt_r  <= '0;
          drop_r <= 1'b0;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.rk_capi) begin
      hi_r   <= hgt_rdata;
      rank_r <= '0;
      j_r    <= '0;
    end
    if (cmd.rk_cmp) begin
      j_r <= j_r + IDX_W'(1);
      if (rank_up) begin
        rank_r <= rank_r + IDX_W'(1);
      end
    end
    if (cmd.pk_rdr) begin
      r_r <= ord_rdata;
    end
    if (cmd.pk_cap) begin
      w_r <= wid_rdata;
      h_r <= hgt_rdata;
      s_r <= (fit_r == FIT_FIRST) ? '0 : shelves_r[IDX_W-1:0] - IDX_W'(1);
    end
    if (cmd.pk_chk) begin
      used_r <= rd_used;
      fill_r <= rd_fill;
      if (!stat.fits) begin
        s_r <= s_r + IDX_W'(1);
      end
    end
    if (cmd.ot_rdh) begin
      pshelf_r <= plc_rdata[PLC_W-1:IDX_W];
      pslot_r  <= plc_rdata[IDX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ot_emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ot_emit && out_free) begin
      o_shelf_r  <= 5'(pshelf_r);
      o_slot_r   <= 5'(pslot_r);
      o_height_r <= 16'(sh_rdata);
      o_count_r  <= 6'(shelves_r);
      o_ovf_r    <= drop_r;
      o_last_r   <= stat.k_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.shelf_index  = o_shelf_r;
  assign out_ch.slot_index   = o_slot_r;
  assign out_ch.shelf_height = o_height_r;
  assign out_ch.shelf_count  = o_count_r;
  assign out_ch.overflow     = o_ovf_r;
  assign out_ch.last_result  = o_last_r;

  assign stat.last_beat = accept && in_ch.last_rect;
  assign stat.j_last    = (CNT_W'(j_r) + CNT_W'(1)) == cnt_r;
  assign stat.i_last    = (CNT_W'(i_r) + CNT_W'(1)) == cnt_r;
  assign stat.k_last    = (CNT_W'(k_r) + CNT_W'(1)) == cnt_r;
  assign stat.no_shelf  = shelves_r == '0;
  assign stat.fits      = sum <= SUM_W'(strip_r);
  assign stat.s_last    = (CNT_W'(s_r) + CNT_W'(1)) == shelves_r;
  assign stat.out_free  = out_free;
endmodule

FILE: rtl/core/shelf_strip_packer_top.sv
// loading accepts one rectangle beat per cycle, n = rectangles held (at most MAX_RECTS)
// ranking: n passes over the height memory, one per held rectangle, through its single read port
// packing: per rectangle, read its order and size, walk the shelves for a fit, then add or open one
// unloading: each result beat is read through the placement and shelf-height memories
// synchronous active-low reset: loader empty, controller idle, no result, register defaults
module shelf_strip_packer_top import ssp_pkg::*; #(
  parameter int MAX_RECTS = 32,
  parameter int DIM_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ssp_in_if.sink      in_ch,
  ssp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  // command and status between sequencer and datapath
  ssp_cmd_t  cmd;
  ssp_stat_t stat;

  // sequencer: load, rank by height, pack shelves, unload in load order
  ssp_ctrl u_ctrl (
    .clk,
    .rst_n,
    .stat,
    .cmd
  );

  // datapath: stores, counters, fit check and output register
  ssp_dp #(
    .MAX_RECTS(MAX_RECTS),
    .DIM_BITS (DIM_BITS)
  ) u_dp (
    .clk,
    .rst_n,
    .in_ch,
    .out_ch,
    .cfg_we,
    .cfg_index,
    .cfg_wdata,
    .cmd,
    .stat
  );
endmodule

FILE: rtl/core/ssp_chk.sv
module ssp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [4:0] out_shelf,
  input logic [5:0] out_count
);
  // stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // loading stops once the last rectangle is taken
  a_pack_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("loader still open after last rectangle");

  // a non-final result on show means more follow, so the loader stays closed
  a_unload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("loader reopened mid unload");

  // every result sits on an opened shelf
  a_shelf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count != 6'd0) && ({1'b0, out_shelf} < out_count))
    else $error("shelf index beyond shelf count");
endmodule

bind shelf_strip_packer_top ssp_chk u_ssp_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_last  (in_ch.last_rect),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_last (out_ch.last_result),
  .out_shelf(out_ch.shelf_index),
  .out_count(out_ch.shelf_count)
);

FILE: sim/shelf_strip_packer_top_tb.sv
`timescale 1ns / 1ps

module shelf_strip_packer_top_tb;
  import ssp_pkg::*;

  localparam int RACK_DEPTH = 32;

  typedef struct {
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } rect_t;

  typedef struct {
    logic [4:0]  shelf;
    logic [4:0]  slot;
    logic [15:0] height;
    logic [5:0]  count;
    logic        ovf;
    logic        last;
  } placement_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_wdata;

  ssp_in_if  in_ch ();
  ssp_out_if out_ch ();

  shelf_strip_packer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rectangles waiting to be sent, and placements waiting to come back
  rect_t      rects_pending[$];
  placement_t placements_due[$];

  // mirror of the block: held rectangles and the register values
  logic [15:0] held_w[RACK_DEPTH];
  logic [15:0] held_h[RACK_DEPTH];
  int          held_n;
  logic        held_drop;
  logic [15:0] strip_width;
  logic        fit_mode;

  int errors;
  int sets_packed;
  int overflow_sets;
  int beats_checked;
  int rects_sent;
  bit quiet;       // no idling on either side when set
  int send_gap;
  int sink_stall;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // order by descending height (ties keep load order), pack onto shelves,
  // then queue one placement per held rectangle in load order
  function automatic void pack_held_set();
    int     order[RACK_DEPTH];
    longint used[RACK_DEPTH];
    int     shelf_h[RACK_DEPTH];
    int     fill[RACK_DEPTH];
    int     on_shelf[RACK_DEPTH];
    int     in_slot[RACK_DEPTH];
    int     shelves, chosen, first, j, r;
    placement_t p;
    for (int i = 0; i < held_n; i++) begin
      j = i;
      while (j > 0 && held_h[order[j-1]] < held_h[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    shelves = 0;
    for (int i = 0; i < held_n; i++) begin
      r = order[i];
      chosen = shelves;
      if (shelves > 0) begin
        first = (fit_mode == FIT_FIRST) ? 0 : shelves - 1;
        for (int s = first; s < shelves; s++) begin
          if (used[s] + held_w[r] <= strip_width) begin
            chosen = s;
            break;
          end
        end
      end
      if (chosen == shelves) begin
        used[chosen] = held_w[r];
        shelf_h[chosen] = held_h[r];
        fill[chosen] = 1;
        shelves++;
        on_shelf[r] = chosen;
        in_slot[r] = 0;
      end else begin
        used[chosen] += held_w[r];
        on_shelf[r] = chosen;
        in_slot[r] = fill[chosen];
        fill[chosen]++;
      end
    end
    for (int k = 0; k < held_n; k++) begin
      p.shelf  = on_shelf[k][4:0];
      p.slot   = in_slot[k][4:0];
      p.height = shelf_h[on_shelf[k]][15:0];
      p.count  = shelves[5:0];
      p.ovf    = held_drop;
      p.last   = (k == held_n - 1);
      placements_due.insert(placements_due.size(), p);
    end
    sets_packed++;
    if (held_drop) overflow_sets++;
    held_n = 0;
    held_drop = 1'b0;
  endfunction

  function automatic void take_rect(logic [15:0] w, logic [15:0] h, logic last);
    if (held_n < RACK_DEPTH) begin
      held_w[held_n] = w;
      held_h[held_n] = h;
      held_n++;
    end else begin
      held_drop = 1'b1;
    end
    if (last) pack_held_set();
  endfunction

  // driver: one beat in flight, fed from rects_pending, random gaps between beats
  always @(posedge clk) begin
    logic  nxt_valid;
    int    gap_nxt;
    rect_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      nxt_valid = in_ch.valid && !in_ch.ready;
      gap_nxt = send_gap;
      if (in_ch.valid && in_ch.ready) begin
        take_rect(in_ch.rect_width, in_ch.rect_height, in_ch.last_rect);
        rects_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) gap_nxt = $urandom_range(1, 11);
      end else if (!nxt_valid && gap_nxt > 0) begin
        gap_nxt = gap_nxt - 1;
      end
      if (!nxt_valid && gap_nxt == 0 && rects_pending.size() > 0) begin
        r = rects_pending.pop_front();
        in_ch.rect_width  <= r.w;
        in_ch.rect_height <= r.h;
        in_ch.last_rect   <= r.last;
        nxt_valid = 1'b1;
      end
      send_gap <= gap_nxt;
      in_ch.valid <= nxt_valid;
    end
  end

  // monitor: random stall bursts on ready, each result beat checked in order
  always @(posedge clk) begin
    placement_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (placements_due.size() == 0) begin
          report_mismatch("queued placements", 0, 1);
        end else begin
          want = placements_due.pop_front();
          if (out_ch.shelf_index !== want.shelf)
            report_mismatch("shelf_index", out_ch.shelf_index, want.shelf);
          if (out_ch.slot_index !== want.slot)
            report_mismatch("slot_index", out_ch.slot_index, want.slot);
          if (out_ch.shelf_height !== want.height)
            report_mismatch("shelf_height", out_ch.shelf_height, want.height);
          if (out_ch.shelf_count !== want.count)
            report_mismatch("shelf_count", out_ch.shelf_count, want.count);
          if (out_ch.overflow !== want.ovf)
            report_mismatch("overflow", out_ch.overflow, want.ovf);
          if (out_ch.last_result !== want.last)
            report_mismatch("last_result", out_ch.last_result, want.last);
        end
      end
      if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        sink_stall <= $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_STRIP_WIDTH) strip_width = val;
    else fit_mode = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] width, logic mode);
    write_reg(CFG_STRIP_WIDTH, width);
    write_reg(CFG_FIT_MODE, {15'd0, mode});
  endtask

  // sender holds off until every beat is out and every placement is back
  task automatic drain();
    do @(posedge clk);
    while (rects_pending.size() != 0 || in_ch.valid || placements_due.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic push_rect(int w, int h, bit last);
    rect_t r;
    r.w = w[15:0];
    r.h = h[15:0];
    r.last = last;
    rects_pending.insert(rects_pending.size(), r);
  endtask

  // a dimension: mostly small against the strip, sometimes extreme or full range
  function automatic int pick_dim(int span);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(0, 65535);
      default: return $urandom_range(1, (span < 2) ? 2 : span);
    endcase
  endfunction

  task automatic push_random_set(int n);
    int hspan;
    hspan = $urandom_range(0, 1) ? 6 : 4000;   // few heights gives many ties
    for (int i = 0; i < n; i++)
      push_rect(pick_dim(strip_width / 3 + 1), pick_dim(hspan), i == n - 1);
  endtask

  initial begin
    int n;
    errors = 0;
    sets_packed = 0;
    overflow_sets = 0;
    beats_checked = 0;
    rects_sent = 0;
    held_n = 0;
    held_drop = 1'b0;
    strip_width = STRIP_WIDTH_RST;
    fit_mode = FIT_MODE_RST;
    quiet = 1'b0;
    send_gap = 0;
    sink_stall = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_STRIP_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rect_width = '0;
    in_ch.rect_height = '0;
    in_ch.last_rect = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, first-fit: zero sizes, full-range sizes, equal heights, exact fit
    set_config(16'd100, FIT_FIRST);
    push_rect(30, 10, 0);
    push_rect(70, 10, 0);
    push_rect(50, 20, 0);
    push_rect(0, 0, 0);
    push_rect(65535, 65535, 0);
    push_rect(40, 10, 1);
    push_rect(100, 5, 1);   // single rectangle that fills the strip exactly
    drain();

    // zero strip width, next-fit: only zero-width rectangles share a shelf
    set_config(16'd0, FIT_NEXT);
    push_rect(0, 3, 0);
    push_rect(5, 3, 0);
    push_rect(0, 3, 0);
    push_rect(1, 65535, 1);
    drain();

    // widest strip, next-fit
    set_config(16'd65535, FIT_NEXT);
    push_rect(65535, 1, 0);
    push_rect(1, 1, 0);
    push_rect(0, 2, 1);
    push_rect(32768, 7, 0);
    push_rect(32767, 7, 1);
    drain();

    // narrow strip where first-fit reuses an older shelf and next-fit cannot
    for (int m = 0; m < 2; m++) begin
      set_config(16'd10, m ? FIT_FIRST : FIT_NEXT);
      push_rect(6, 9, 0);
      push_rect(6, 8, 0);
      push_rect(4, 7, 0);
      push_rect(4, 6, 0);
      push_rect(3, 5, 1);
      drain();
    end

    // random sets under random settings; a few full or overflowing sets
    while (rects_sent < 230) begin
      case ($urandom_range(0, 5))
        0: set_config(16'd1, 1'($urandom_range(0, 1)));
        1: set_config(16'hffff, 1'($urandom_range(0, 1)));
        2: set_config(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        default: set_config(16'($urandom_range(2, 300)), 1'($urandom_range(0, 1)));
      endcase
      for (int s = 0; s < $urandom_range(1, 4); s++) begin
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
        push_random_set(n);
      end
      if (rects_sent > 190) quiet = 1'b1;
      drain();
    end

    $display("packed %0d sets (%0d with dropped rectangles), %0d result beats checked",
             sets_packed, overflow_sets, beats_checked);
    $display("both fit modes, strip widths from zero to full range, %0d rectangles sent",
             rects_sent);
    if (errors == 0 && placements_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d placements outstanding", placements_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
